[hdl/wms_pkg.sv]
// Shared constants and types for the wildcard match stream unit.
`timescale 1ns / 1ps
`default_nettype none

package wms_pkg;

	// Default maximum pattern length in bytes.
	localparam int unsigned MAX_PATTERN_DEF = 32;

	// Wildcard bytes: '*' matches any run, '?' matches any single byte.
	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE  = 8'h3F;

	// Command codes carried in the action field.
	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_START  = 2'd2,
		ACT_TEXT   = 2'd3
	} action_t;

endpackage

`default_nettype wire

[hdl/wms_cmd_if.sv]
// Command channel interface: action and symbol with a valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface wms_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] symbol;

	modport source (output valid, output action, output symbol, input ready);
	modport sink (input valid, input action, input symbol, output ready);
endinterface

`default_nettype wire

[hdl/wms_res_if.sv]
// Result channel interface: match and overflow flags with a valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface wms_res_if;
	logic valid;
	logic ready;
	logic match;
	logic overflow;

	modport source (output valid, output match, output overflow, input ready);
	modport sink (input valid, input match, input overflow, output ready);
endinterface

`default_nettype wire

[hdl/wms_column.sv]
// Next-column logic of the wildcard match table for one text byte or an empty text.
`timescale 1ns / 1ps
`default_nettype none

module wms_column
	import wms_pkg::*;
#(
	parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int unsigned LEN_W       = $clog2(MAX_PATTERN + 1)
) (
	input  wire logic [MAX_PATTERN-1:0][7:0] pattern,
	input  wire logic [LEN_W-1:0]            len,
	input  wire logic [MAX_PATTERN:0]        column,
	input  wire logic [7:0]                  symbol,
	output      logic [MAX_PATTERN:0]        empty_column,
	output      logic [MAX_PATTERN:0]        text_column
);

	// Each bit i covers the first i pattern bytes. The empty-text column is the
	// run of leading stars; the text column applies the diagonal rule first,
	// then lets a star take the bit just below it in the new column or its own bit in the old one.
	always_comb begin
		logic       in_len;
		logic [7:0] p;
		empty_column    = '0;
		text_column     = '0;
		empty_column[0] = 1'b1;
		for (int i = 1; i <= int'(MAX_PATTERN); i++) begin
			in_len          = (LEN_W'(i) <= len);
			p               = pattern[i-1];
			empty_column[i] = empty_column[i-1] & (p == STAR_BYTE) & in_len;
			priority if (!in_len) begin
				text_column[i] = 1'b0;
			end else if (p == symbol || p == ANY_BYTE) begin
				text_column[i] = column[i-1];
			end else if (p == STAR_BYTE) begin
				text_column[i] = text_column[i-1] | column[i];
			end else begin
				text_column[i] = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/wildcard_match_stream_unit.sv]
// Top level of the streaming wildcard matcher with '?' and '*' support.
`timescale 1ns / 1ps
`default_nettype none

// The unit loads a pattern of up to MAX_PATTERN bytes one byte at a time and
// then matches a text streamed in byte by byte, keeping one column of the
// match table as a bit vector. Commands: clear the pattern, append a pattern
// byte (bytes past the maximum are dropped and flag overflow), start a text
// (one result: does the empty text match), and text byte (one result: does
// the text so far match the whole pattern). Appending restarts any text in
// progress. Every command waits in the input register while the column
// logic evaluates it, and its result is then held in the result register.
// A new command is taken every cycle; the input stalls only while a finished
// result waits to be taken. The throughput is set by the column update,
// whose star chain spans the whole pattern.
module wildcard_match_stream_unit
	import wms_pkg::*;
#(
	parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	wms_cmd_if.sink  cmd,
	wms_res_if.source res
);

	localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// Input register.
	logic       valid_s1;
	action_t    action_s1;
	logic [7:0] symbol_s1;

	// Pattern and match state.
	logic [MAX_PATTERN-1:0][7:0] pattern_q;
	logic [LEN_W-1:0]            len_q;
	logic [MAX_PATTERN:0]        column_q;
	logic                        overflow_q;

	// Result register.
	logic res_valid_q;
	logic match_q;
	logic res_overflow_q;

	logic                 produces;
	logic                 advance;
	logic                 not_full;
	logic [MAX_PATTERN:0] empty_column;
	logic [MAX_PATTERN:0] text_column;
	logic [MAX_PATTERN:0] append_column;

	wms_column #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_column (
		.pattern      (pattern_q),
		.len          (len_q),
		.column       (column_q),
		.symbol       (symbol_s1),
		.empty_column (empty_column),
		.text_column  (text_column)
	);

	// Handshake: a command leaves the input register unless its result would
	// overwrite one still waiting.
	assign produces  = (action_s1 == ACT_START) || (action_s1 == ACT_TEXT);
	assign advance   = valid_s1 && (!produces || !res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign not_full  = (len_q < LEN_W'(MAX_PATTERN));

	// Empty-text column after an append: extend the star run by the new byte.
	always_comb begin
		append_column = empty_column;
		if (not_full && symbol_s1 == STAR_BYTE) begin
			for (int i = 1; i <= int'(MAX_PATTERN); i++) begin
				if ((LEN_W+1)'(i) == ({1'b0, len_q} + (LEN_W+1)'(1))) begin
					append_column[i] = empty_column[i-1];
				end
			end
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1 <= action_t'(cmd.action);
			symbol_s1 <= cmd.symbol;
		end
	end

	// Pattern bytes: no reset, entries at or above the length are never used.
	always_ff @(posedge clk) begin
		if (advance && action_s1 == ACT_APPEND && not_full) begin
			pattern_q[len_q[IDX_W-1:0]] <= symbol_s1;
		end
	end

	// Length, column and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			column_q   <= (MAX_PATTERN+1)'(1);
			overflow_q <= 1'b0;
		end else if (advance) begin
			unique case (action_s1)
				ACT_CLEAR: begin
					len_q      <= '0;
					column_q   <= (MAX_PATTERN+1)'(1);
					overflow_q <= 1'b0;
				end
				ACT_APPEND: begin
					column_q <= append_column;
					if (not_full) begin
						len_q <= len_q + LEN_W'(1);
					end else begin
						overflow_q <= 1'b1;
					end
				end
				ACT_START: begin
					column_q <= empty_column;
				end
				ACT_TEXT: begin
					column_q <= text_column;
				end
				default: begin
					column_q <= column_q;
				end
			endcase
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && produces) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload: the column bit at the full pattern length.
	always_ff @(posedge clk) begin
		if (advance && produces) begin
			match_q        <= (action_s1 == ACT_TEXT) ? text_column[len_q] : empty_column[len_q];
			res_overflow_q <= overflow_q;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.match    = match_q;
	assign res.overflow = res_overflow_q;

endmodule

`default_nettype wire

[hdl/wms_checker.sv]
// Port-level checks for the wildcard match stream unit and their binding.
`timescale 1ns / 1ps
`default_nettype none

module wms_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_ready,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic res_match,
	input wire logic res_overflow
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_match) && $stable(res_overflow))
		else $error("result changed while stalled");

	// The command side stalls only behind a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid && !res_ready)
		else $error("command stalled with the result slot free");

	// A new result only follows a command transaction that passed through the input register without stalling.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
		else $error("result appeared without a preceding command");

endmodule

bind wildcard_match_stream_unit wms_checker u_wms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_match    (res.match),
	.res_overflow (res.overflow)
);

`default_nettype wire
